// File: hdl/dual_range_wall_align_sequencer_core_defines.svh
// assertion macros shared by the checker of the wall alignment sequencer
// no dependencies; include with the bare file name
`ifndef DUAL_RANGE_WALL_ALIGN_SEQUENCER_CORE_DEFINES_SVH
`define DUAL_RANGE_WALL_ALIGN_SEQUENCER_CORE_DEFINES_SVH

// same-cycle implication, disabled while reset is asserted
`define DRWAS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled while reset is asserted
`define DRWAS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hdl/drwas_pkg.sv
// shared types and constants of the wall alignment sequencer
// no dependencies; used by the core and its checker
`default_nettype none

package drwas_pkg;

  // input payload widths
  localparam int IN_RANGE_W    = 10;
  localparam int S_TDATA_W     = 24;
  localparam int M_TDATA_W     = 24;
  localparam int CFG_ADDR_W    = 3;
  localparam int CFG_DATA_W    = 16;

  // output field positions in m_axis_tdata
  localparam int CMD_W         = 3;
  localparam int PHASE_W       = 4;
  localparam int AVG_W         = 10;
  localparam int CMD_LSB       = 0;
  localparam int FINISHED_BIT  = 3;
  localparam int FAULT_BIT     = 4;
  localparam int PHASE_LSB     = 5;
  localparam int AVG_LSB       = 9;
  localparam int OUT_USED_W    = 19;

  // timing and validity constants
  localparam int INVALID_FROM    = 300;
  localparam int SAMPLE_GAP_MS   = 80;
  localparam int CONFIRM_GAP_MS  = 50;
  localparam int APPROACH_GAP_MS = 10;

  // phase code values seen on the output
  localparam logic [PHASE_W-1:0] PHASE_CODE_INIT = 4'd1;

  // drive commands
  typedef enum logic [CMD_W-1:0] {
    CMD_NONE = 3'd0,
    CMD_STOP = 3'd1,
    CMD_CW   = 3'd2,
    CMD_CCW  = 3'd3,
    CMD_FWD  = 3'd4
  } cmd_e;

  // configuration register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_EQUAL_TOL    = 3'd0,
    REG_CONFIRM_NEED = 3'd1,
    REG_FAULT_LIMIT  = 3'd2,
    REG_FAULT_TMO    = 3'd3,
    REG_TURN_TIME    = 3'd4,
    REG_TARGET_DIST  = 3'd5,
    REG_DIST_SLACK   = 3'd6
  } reg_idx_e;

  // register reset values
  localparam logic [7:0]  RST_EQUAL_TOL    = 8'd2;
  localparam logic [7:0]  RST_CONFIRM_NEED = 8'd3;
  localparam logic [7:0]  RST_FAULT_LIMIT  = 8'd5;
  localparam logic [15:0] RST_FAULT_TMO    = 16'd3000;
  localparam logic [15:0] RST_TURN_TIME    = 16'd50;
  localparam logic [8:0]  RST_TARGET_DIST  = 9'd15;
  localparam logic [7:0]  RST_DIST_SLACK   = 8'd1;

endpackage

`default_nettype wire

// File: hdl/dual_range_wall_align_sequencer_core.sv
// wall alignment sequencer: phase machine, timers, fault counting, output register
// depends on drwas_pkg
//
// usage
//   s_axis carries one item per transfer: tuser is the kind (0 one-millisecond
//   tick, 1 start), tdata holds the latest left and right range readings.
//   m_axis returns exactly one result per item: drive command, finished flag,
//   fault flag, phase code and the last approach mean.
//   cfg_* writes one register per transfer (index, data); always ready. The user
//   must write only while no item is in flight; the block does not enforce it.
// latency and throughput
//   the phase step is done in the cycle an item is accepted; its result is
//   held in the output register from the next cycle on. One item per cycle
//   is taken, bounded only by the single output register.
// reset
//   rst_ni clears the phase to idle, the millisecond clock, timers, counters
//   and held readings, and loads register defaults; no result is pending.
// stall
//   while a result waits untaken, s_axis_tready is low; it rises in the
//   cycle the receiver takes the result, so a new item can enter then.
`default_nettype none

module dual_range_wall_align_sequencer_core #(
  parameter int TIME_BITS  = 32,
  parameter int RANGE_BITS = 10
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  // input items
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  // [9:0] left_range_cm, [19:10] right_range_cm, [23:20] zero
  input  wire logic [drwas_pkg::S_TDATA_W-1:0]   s_axis_tdata,
  // [0] kind
  input  wire logic                              s_axis_tuser,
  // result items
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  // [2:0] drive_command, [3] finished, [4] fault_skip, [8:5] phase_code,
  // [18:9] average_cm, [23:19] zero
  output logic [drwas_pkg::M_TDATA_W-1:0]        m_axis_tdata,
  // configuration writes
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [drwas_pkg::CFG_ADDR_W-1:0]  cfg_addr_i,
  input  wire logic [drwas_pkg::CFG_DATA_W-1:0]  cfg_data_i
);

  import drwas_pkg::*;

  typedef enum logic [PHASE_W-1:0] {
    PH_IDLE   = 4'd0,
    PH_INIT   = 4'd1,
    PH_MEAS_L = 4'd2,
    PH_MEAS_R = 4'd3,
    PH_CHECK  = 4'd4,
    PH_TURN   = 4'd5,
    PH_CONF_L = 4'd6,
    PH_CONF_R = 4'd7,
    PH_FWD    = 4'd8,
    PH_APP_L  = 4'd9,
    PH_APP_R  = 4'd10,
    PH_DONE   = 4'd11
  } phase_e;

  localparam int SW = (RANGE_BITS > IN_RANGE_W) ? RANGE_BITS : IN_RANGE_W;
  localparam logic [SW-1:0] RANGE_MAX = SW'((1 << RANGE_BITS) - 1);

  // configuration registers
  logic [7:0]  equal_tol_q, confirm_need_q, fault_limit_q, dist_slack_q;
  logic [15:0] fault_tmo_q, turn_time_q;
  logic [8:0]  target_dist_q;

  // sequencer state
  phase_e                phase_q, phase_d;
  logic [TIME_BITS-1:0]  now_q, now_d, last_act_q, last_act_d, fault_start_q, fault_start_d;
  logic [RANGE_BITS-1:0] held_l_q, held_l_d, held_r_q, held_r_d, avg_q, avg_d;
  logic [7:0]            confirm_q, confirm_d, fault_cnt_q, fault_cnt_d;
  logic                  fault_done_q, fault_done_d;

  // output register
  logic                  out_valid_q;
  logic [M_TDATA_W-1:0]  out_data_q;

  // per-item intermediate values
  logic                  in_xfer, is_start;
  logic [SW-1:0]         lv_w, rv_w;
  logic [RANGE_BITS-1:0] lv, rv;
  logic [TIME_BITS-1:0]  now_n, act_el, fault_el;
  logic [7:0]            fault_inc, confirm_inc;
  logic                  fault_hit;
  logic [RANGE_BITS-1:0] chk_l, chk_r, diff;
  logic                  pair_bad, aligned;
  logic [RANGE_BITS:0]   pair_sum;
  logic [SW:0]           stop_at;
  cmd_e                  cmd;

  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign is_start      = s_axis_tuser;
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign cfg_ready_o   = 1'b1;

  // readings saturated to the held width
  assign lv_w = SW'(s_axis_tdata[IN_RANGE_W-1:0]);
  assign rv_w = SW'(s_axis_tdata[2*IN_RANGE_W-1:IN_RANGE_W]);
  assign lv   = (lv_w > RANGE_MAX) ? RANGE_BITS'(RANGE_MAX) : RANGE_BITS'(lv_w);
  assign rv   = (rv_w > RANGE_MAX) ? RANGE_BITS'(RANGE_MAX) : RANGE_BITS'(rv_w);

  // timers, measured against the advanced clock
  assign now_n    = now_q + TIME_BITS'(1);
  assign act_el   = now_n - last_act_q;
  assign fault_el = (fault_cnt_q == 8'd0) ? '0 : now_n - fault_start_q;

  // saturating counters and fault limit test
  assign fault_inc   = (fault_cnt_q == 8'hFF) ? fault_cnt_q : fault_cnt_q + 8'd1;
  assign confirm_inc = (confirm_q == 8'hFF) ? confirm_q : confirm_q + 8'd1;
  assign fault_hit   = (fault_inc >= fault_limit_q) ||
                       (fault_el >= TIME_BITS'(fault_tmo_q));

  // pair checks: the right reading is fresh in the right-hand phases
  assign chk_l    = held_l_q;
  assign chk_r    = (phase_q == PH_CONF_R || phase_q == PH_APP_R) ? rv : held_r_q;
  assign pair_bad = (chk_l == '0) || (chk_l >= RANGE_BITS'(INVALID_FROM)) ||
                    (chk_r == '0) || (chk_r >= RANGE_BITS'(INVALID_FROM));
  assign diff     = (chk_l > chk_r) ? chk_l - chk_r : chk_r - chk_l;
  assign aligned  = diff <= RANGE_BITS'(equal_tol_q);
  assign pair_sum = {1'b0, chk_l} + {1'b0, chk_r};
  assign stop_at  = (SW+1)'(target_dist_q) + (SW+1)'(dist_slack_q);

  // phase step for one item
  always_comb begin
    phase_d       = phase_q;
    now_d         = now_q;
    last_act_d    = last_act_q;
    fault_start_d = fault_start_q;
    held_l_d      = held_l_q;
    held_r_d      = held_r_q;
    avg_d         = avg_q;
    confirm_d     = confirm_q;
    fault_cnt_d   = fault_cnt_q;
    fault_done_d  = fault_done_q;
    cmd           = CMD_NONE;
    if (is_start) begin
      phase_d       = PH_INIT;
      last_act_d    = now_q;
      confirm_d     = 8'd0;
      fault_cnt_d   = 8'd0;
      fault_start_d = '0;
      fault_done_d  = 1'b0;
    end else begin
      now_d = now_n;
      unique case (phase_q)
        PH_INIT: begin
          phase_d    = PH_MEAS_L;
          last_act_d = now_n;
        end
        PH_MEAS_L: begin
          if (act_el >= TIME_BITS'(SAMPLE_GAP_MS)) begin
            held_l_d   = lv;
            last_act_d = now_n;
            phase_d    = PH_MEAS_R;
          end
        end
        PH_MEAS_R: begin
          if (act_el >= TIME_BITS'(SAMPLE_GAP_MS)) begin
            held_r_d   = rv;
            last_act_d = now_n;
            phase_d    = PH_CHECK;
          end
        end
        PH_CHECK: begin
          if (pair_bad) begin
            cmd         = CMD_STOP;
            fault_cnt_d = fault_inc;
            if (fault_cnt_q == 8'd0) fault_start_d = now_n;
            if (fault_hit) begin
              phase_d      = PH_DONE;
              fault_done_d = 1'b1;
            end else begin
              phase_d    = PH_MEAS_L;
              last_act_d = now_n;
            end
          end else begin
            fault_cnt_d   = 8'd0;
            fault_start_d = '0;
            last_act_d    = now_n;
            if (aligned) begin
              confirm_d = 8'd0;
              phase_d   = PH_CONF_L;
            end else begin
              cmd     = (chk_l > chk_r) ? CMD_CW : CMD_CCW;
              phase_d = PH_TURN;
            end
          end
        end
        PH_TURN: begin
          if (act_el >= TIME_BITS'(turn_time_q)) begin
            cmd        = CMD_STOP;
            phase_d    = PH_MEAS_L;
            last_act_d = now_n;
          end
        end
        PH_CONF_L: begin
          if (act_el >= TIME_BITS'(CONFIRM_GAP_MS)) begin
            held_l_d   = lv;
            last_act_d = now_n;
            phase_d    = PH_CONF_R;
          end
        end
        PH_CONF_R: begin
          if (act_el >= TIME_BITS'(CONFIRM_GAP_MS)) begin
            held_r_d   = rv;
            last_act_d = now_n;
            if (aligned) begin
              confirm_d = confirm_inc;
              if (confirm_inc >= confirm_need_q) begin
                cmd     = CMD_STOP;
                phase_d = PH_FWD;
              end else begin
                phase_d = PH_CONF_L;
              end
            end else begin
              confirm_d = 8'd0;
              phase_d   = PH_MEAS_L;
            end
          end
        end
        PH_FWD: begin
          cmd        = CMD_FWD;
          phase_d    = PH_APP_L;
          last_act_d = now_n;
        end
        PH_APP_L: begin
          if (act_el >= TIME_BITS'(APPROACH_GAP_MS)) begin
            held_l_d   = lv;
            last_act_d = now_n;
            phase_d    = PH_APP_R;
          end
        end
        PH_APP_R: begin
          if (act_el >= TIME_BITS'(APPROACH_GAP_MS)) begin
            held_r_d   = rv;
            last_act_d = now_n;
            if (pair_bad) begin
              cmd         = CMD_STOP;
              fault_cnt_d = fault_inc;
              if (fault_cnt_q == 8'd0) fault_start_d = now_n;
              if (fault_hit) begin
                phase_d      = PH_DONE;
                fault_done_d = 1'b1;
              end else begin
                phase_d = PH_FWD;
              end
            end else begin
              fault_cnt_d   = 8'd0;
              fault_start_d = '0;
              avg_d         = pair_sum[RANGE_BITS:1];
              if ((SW+1)'(pair_sum[RANGE_BITS:1]) <= stop_at) begin
                cmd     = CMD_STOP;
                phase_d = PH_DONE;
              end else begin
                phase_d = PH_APP_L;
              end
            end
          end
        end
        default: begin
          // idle and done only let time advance
        end
      endcase
    end
  end

  // state update on each accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_IDLE;
      now_q         <= '0;
      last_act_q    <= '0;
      fault_start_q <= '0;
      held_l_q      <= '0;
      held_r_q      <= '0;
      avg_q         <= '0;
      confirm_q     <= 8'd0;
      fault_cnt_q   <= 8'd0;
      fault_done_q  <= 1'b0;
    end else if (in_xfer) begin
      phase_q       <= phase_d;
      now_q         <= now_d;
      last_act_q    <= last_act_d;
      fault_start_q <= fault_start_d;
      held_l_q      <= held_l_d;
      held_r_q      <= held_r_d;
      avg_q         <= avg_d;
      confirm_q     <= confirm_d;
      fault_cnt_q   <= fault_cnt_d;
      fault_done_q  <= fault_done_d;
    end
  end

  // configuration register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      equal_tol_q    <= RST_EQUAL_TOL;
      confirm_need_q <= RST_CONFIRM_NEED;
      fault_limit_q  <= RST_FAULT_LIMIT;
      fault_tmo_q    <= RST_FAULT_TMO;
      turn_time_q    <= RST_TURN_TIME;
      target_dist_q  <= RST_TARGET_DIST;
      dist_slack_q   <= RST_DIST_SLACK;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_addr_i)
        REG_EQUAL_TOL:    equal_tol_q    <= cfg_data_i[7:0];
        REG_CONFIRM_NEED: confirm_need_q <= cfg_data_i[7:0];
        REG_FAULT_LIMIT:  fault_limit_q  <= cfg_data_i[7:0];
        REG_FAULT_TMO:    fault_tmo_q    <= cfg_data_i;
        REG_TURN_TIME:    turn_time_q    <= cfg_data_i;
        REG_TARGET_DIST:  target_dist_q  <= cfg_data_i[8:0];
        REG_DIST_SLACK:   dist_slack_q   <= cfg_data_i[7:0];
        default: begin
          // unused index, write is dropped
        end
      endcase
    end
  end

  // output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_xfer) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      out_data_q <= {(M_TDATA_W - OUT_USED_W)'(0),
                     AVG_W'(avg_d),
                     PHASE_W'(phase_d),
                     fault_done_d,
                     (phase_d == PH_DONE),
                     cmd};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

`default_nettype wire

// File: hdl/drwas_checker.sv
// port-level checker of the wall alignment sequencer, bound to the core
// depends on drwas_pkg and dual_range_wall_align_sequencer_core_defines.svh
`default_nettype none
`include "dual_range_wall_align_sequencer_core_defines.svh"

module drwas_checker (
  input wire logic                             clk_i,
  input wire logic                             rst_ni,
  input wire logic                             s_axis_tvalid,
  input wire logic                             s_axis_tready,
  input wire logic                             s_axis_tuser,
  input wire logic                             m_axis_tvalid,
  input wire logic                             m_axis_tready,
  input wire logic [drwas_pkg::M_TDATA_W-1:0]  m_axis_tdata
);

  import drwas_pkg::*;

  logic start_xfer;
  logic [PHASE_W-1:0] out_phase;
  logic [CMD_W-1:0]   out_cmd;

  assign start_xfer = s_axis_tvalid && s_axis_tready && s_axis_tuser;
  assign out_phase  = m_axis_tdata[PHASE_LSB +: PHASE_W];
  assign out_cmd    = m_axis_tdata[CMD_LSB +: CMD_W];

  // a stalled result stays put
  `DRWAS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

  // an empty output register never blocks the input
  `DRWAS_ASSERT_NOW(a_in_ready, clk_i, rst_ni, !m_axis_tvalid, s_axis_tready, "input blocked with no result pending")

  // a start transfer yields an init result with no command in the next cycle
  `DRWAS_ASSERT_NEXT(a_start_result, clk_i, rst_ni, start_xfer, m_axis_tvalid && out_phase == PHASE_CODE_INIT && out_cmd == CMD_NONE, "start did not report init")

  // the fault flag only comes with a finished sequence
  `DRWAS_ASSERT_NOW(a_fault_done, clk_i, rst_ni, m_axis_tvalid && m_axis_tdata[FAULT_BIT], m_axis_tdata[FINISHED_BIT], "fault flag without finished")

endmodule

bind dual_range_wall_align_sequencer_core drwas_checker u_drwas_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire

// File: verif/align_step_checker.sv
// checker of the wall alignment sequencer: follows the config, input and result channels,
// predicts every result and compares each result with the oldest prediction
// depends on drwas_pkg
`default_nettype none

module align_step_checker (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             s_axis_tvalid,
  input  wire logic                             s_axis_tready,
  // [9:0] left_range_cm, [19:10] right_range_cm
  input  wire logic [drwas_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  // [0] kind
  input  wire logic                             s_axis_tuser,
  input  wire logic                             m_axis_tvalid,
  input  wire logic                             m_axis_tready,
  // [2:0] drive_command, [3] finished, [4] fault_skip, [8:5] phase_code, [18:9] average_cm
  input  wire logic [drwas_pkg::M_TDATA_W-1:0]  m_axis_tdata,
  input  wire logic                             cfg_valid_i,
  input  wire logic                             cfg_ready_o,
  input  wire logic [drwas_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  wire logic [drwas_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int                                    outstanding_o,
  output int                                    mismatches_o
);

  import drwas_pkg::*;

  // sequencer phases as seen on phase_code
  typedef enum logic [PHASE_W-1:0] {
    SEQ_IDLE   = 4'd0,
    SEQ_INIT   = 4'd1,
    SEQ_MEAS_L = 4'd2,
    SEQ_MEAS_R = 4'd3,
    SEQ_CHECK  = 4'd4,
    SEQ_TURN   = 4'd5,
    SEQ_CONF_L = 4'd6,
    SEQ_CONF_R = 4'd7,
    SEQ_FWD    = 4'd8,
    SEQ_APP_L  = 4'd9,
    SEQ_APP_R  = 4'd10,
    SEQ_DONE   = 4'd11
  } seq_phase_e;

  typedef struct packed {
    cmd_e               cmd;
    logic               finished;
    logic               fault_skip;
    logic [PHASE_W-1:0] phase;
    logic [AVG_W-1:0]   avg_cm;
  } step_result_t;

  localparam logic [7:0] COUNT_CEIL = 8'd255;

  // register copies
  logic [7:0]  tol_cm, confirm_goal, fault_limit, slack_cm;
  logic [15:0] fault_tmo_ms, turn_ms;
  logic [8:0]  target_cm;

  // sequencer state copies
  seq_phase_e             seq_phase;
  logic [31:0]            clock_ms, mark_ms, fault_mark_ms;
  logic [IN_RANGE_W-1:0]  held_l_cm, held_r_cm;
  logic [7:0]             confirms, faults;
  logic                   fault_latched;
  logic [AVG_W-1:0]       avg_cm;

  step_result_t expected_steps[$];
  step_result_t want, next_res;
  int           results_seen;

  function automatic logic [31:0] elapsed_ms(logic [31:0] mark);
    return clock_ms - mark;
  endfunction

  function automatic logic out_of_range(logic [IN_RANGE_W-1:0] v);
    return (v == '0) || (v >= INVALID_FROM);
  endfunction

  function automatic logic [IN_RANGE_W-1:0] spread_cm(logic [IN_RANGE_W-1:0] a,
                                                      logic [IN_RANGE_W-1:0] b);
    return (a > b) ? a - b : b - a;
  endfunction

  // one more invalid pair; limit_hit when count or time limit is met
  task automatic count_fault(output logic limit_hit);
    if (faults == '0) fault_mark_ms = clock_ms;
    if (faults != COUNT_CEIL) faults = faults + 8'd1;
    limit_hit = (faults >= fault_limit) || (elapsed_ms(fault_mark_ms) >= fault_tmo_ms);
  endtask

  task automatic step_sequencer(input logic kind, input logic [IN_RANGE_W-1:0] lv,
                                input logic [IN_RANGE_W-1:0] rv, output step_result_t res);
    cmd_e cmd;
    logic hit;
    int   sum;
    cmd = CMD_NONE;
    if (kind) begin
      // restart from init, readings and mean are kept
      seq_phase     = SEQ_INIT;
      mark_ms       = clock_ms;
      confirms      = '0;
      faults        = '0;
      fault_mark_ms = '0;
      fault_latched = 1'b0;
    end else begin
      clock_ms = clock_ms + 32'd1;
      case (seq_phase)
        SEQ_INIT: begin
          seq_phase = SEQ_MEAS_L;
          mark_ms   = clock_ms;
        end
        SEQ_MEAS_L: begin
          if (elapsed_ms(mark_ms) >= SAMPLE_GAP_MS) begin
            held_l_cm = lv;
            mark_ms   = clock_ms;
            seq_phase = SEQ_MEAS_R;
          end
        end
        SEQ_MEAS_R: begin
          if (elapsed_ms(mark_ms) >= SAMPLE_GAP_MS) begin
            held_r_cm = rv;
            mark_ms   = clock_ms;
            seq_phase = SEQ_CHECK;
          end
        end
        SEQ_CHECK: begin
          if (out_of_range(held_l_cm) || out_of_range(held_r_cm)) begin
            cmd = CMD_STOP;
            count_fault(hit);
            if (hit) begin
              seq_phase     = SEQ_DONE;
              fault_latched = 1'b1;
            end else begin
              seq_phase = SEQ_MEAS_L;
              mark_ms   = clock_ms;
            end
          end else begin
            faults        = '0;
            fault_mark_ms = '0;
            mark_ms       = clock_ms;
            if (spread_cm(held_l_cm, held_r_cm) <= tol_cm) begin
              confirms  = '0;
              seq_phase = SEQ_CONF_L;
            end else begin
              if (held_l_cm > held_r_cm) cmd = CMD_CW;
              else cmd = CMD_CCW;
              seq_phase = SEQ_TURN;
            end
          end
        end
        SEQ_TURN: begin
          if (elapsed_ms(mark_ms) >= turn_ms) begin
            cmd       = CMD_STOP;
            seq_phase = SEQ_MEAS_L;
            mark_ms   = clock_ms;
          end
        end
        SEQ_CONF_L: begin
          if (elapsed_ms(mark_ms) >= CONFIRM_GAP_MS) begin
            held_l_cm = lv;
            mark_ms   = clock_ms;
            seq_phase = SEQ_CONF_R;
          end
        end
        SEQ_CONF_R: begin
          if (elapsed_ms(mark_ms) >= CONFIRM_GAP_MS) begin
            held_r_cm = rv;
            mark_ms   = clock_ms;
            if (spread_cm(held_l_cm, held_r_cm) <= tol_cm) begin
              if (confirms != COUNT_CEIL) confirms = confirms + 8'd1;
              if (confirms >= confirm_goal) begin
                cmd       = CMD_STOP;
                seq_phase = SEQ_FWD;
              end else begin
                seq_phase = SEQ_CONF_L;
              end
            end else begin
              confirms  = '0;
              seq_phase = SEQ_MEAS_L;
            end
          end
        end
        SEQ_FWD: begin
          cmd       = CMD_FWD;
          seq_phase = SEQ_APP_L;
          mark_ms   = clock_ms;
        end
        SEQ_APP_L: begin
          if (elapsed_ms(mark_ms) >= APPROACH_GAP_MS) begin
            held_l_cm = lv;
            mark_ms   = clock_ms;
            seq_phase = SEQ_APP_R;
          end
        end
        SEQ_APP_R: begin
          if (elapsed_ms(mark_ms) >= APPROACH_GAP_MS) begin
            held_r_cm = rv;
            mark_ms   = clock_ms;
            if (out_of_range(held_l_cm) || out_of_range(held_r_cm)) begin
              cmd = CMD_STOP;
              count_fault(hit);
              if (hit) begin
                seq_phase     = SEQ_DONE;
                fault_latched = 1'b1;
              end else begin
                seq_phase = SEQ_FWD;
              end
            end else begin
              faults        = '0;
              fault_mark_ms = '0;
              sum           = int'(held_l_cm) + int'(held_r_cm);
              avg_cm        = AVG_W'(sum >> 1);
              // stop test at full width so target plus slack cannot wrap
              if (int'(avg_cm) <= int'(target_cm) + int'(slack_cm)) begin
                cmd       = CMD_STOP;
                seq_phase = SEQ_DONE;
              end else begin
                seq_phase = SEQ_APP_L;
              end
            end
          end
        end
        default: ;
      endcase
    end
    res.cmd        = cmd;
    res.finished   = (seq_phase == SEQ_DONE);
    res.fault_skip = fault_latched;
    res.phase      = seq_phase;
    res.avg_cm     = avg_cm;
  endtask

  task automatic report_mismatch(input string what, input int got, input int exp_val);
    $display("result %0d %s: got %0d, expected %0d", results_seen, what, got, exp_val);
    mismatches_o = mismatches_o + 1;
  endtask

  // predict on each input transfer, compare on each result transfer
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_cm        = RST_EQUAL_TOL;
      confirm_goal  = RST_CONFIRM_NEED;
      fault_limit   = RST_FAULT_LIMIT;
      fault_tmo_ms  = RST_FAULT_TMO;
      turn_ms       = RST_TURN_TIME;
      target_cm     = RST_TARGET_DIST;
      slack_cm      = RST_DIST_SLACK;
      seq_phase     = SEQ_IDLE;
      clock_ms      = '0;
      mark_ms       = '0;
      fault_mark_ms = '0;
      held_l_cm     = '0;
      held_r_cm     = '0;
      confirms      = '0;
      faults        = '0;
      fault_latched = 1'b0;
      avg_cm        = '0;
      results_seen  = 0;
      mismatches_o  = 0;
      expected_steps.delete();
      outstanding_o <= 0;
    end else begin
      // register write transfer
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_addr_i)
          REG_EQUAL_TOL:    tol_cm       = cfg_data_i[7:0];
          REG_CONFIRM_NEED: confirm_goal = cfg_data_i[7:0];
          REG_FAULT_LIMIT:  fault_limit  = cfg_data_i[7:0];
          REG_FAULT_TMO:    fault_tmo_ms = cfg_data_i[15:0];
          REG_TURN_TIME:    turn_ms      = cfg_data_i[15:0];
          REG_TARGET_DIST:  target_cm    = cfg_data_i[8:0];
          REG_DIST_SLACK:   slack_cm     = cfg_data_i[7:0];
          default: ;
        endcase
      end

      // result transfer against the oldest prediction
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_steps.size() == 0) begin
          report_mismatch("arrived with nothing pending", 1, 0);
        end else begin
          want = expected_steps.pop_front();
          if (m_axis_tdata[CMD_LSB +: CMD_W] != want.cmd)
            report_mismatch("drive_command", int'(m_axis_tdata[CMD_LSB +: CMD_W]),
                            int'(want.cmd));
          if (m_axis_tdata[FINISHED_BIT] != want.finished)
            report_mismatch("finished", int'(m_axis_tdata[FINISHED_BIT]),
                            int'(want.finished));
          if (m_axis_tdata[FAULT_BIT] != want.fault_skip)
            report_mismatch("fault_skip", int'(m_axis_tdata[FAULT_BIT]),
                            int'(want.fault_skip));
          if (m_axis_tdata[PHASE_LSB +: PHASE_W] != want.phase)
            report_mismatch("phase_code", int'(m_axis_tdata[PHASE_LSB +: PHASE_W]),
                            int'(want.phase));
          if (m_axis_tdata[AVG_LSB +: AVG_W] != want.avg_cm)
            report_mismatch("average_cm", int'(m_axis_tdata[AVG_LSB +: AVG_W]),
                            int'(want.avg_cm));
          if (m_axis_tdata[M_TDATA_W-1:OUT_USED_W] != '0)
            report_mismatch("pad bits", int'(m_axis_tdata[M_TDATA_W-1:OUT_USED_W]), 0);
        end
        results_seen = results_seen + 1;
      end

      // input transfer
      if (s_axis_tvalid && s_axis_tready) begin
        step_sequencer(s_axis_tuser, s_axis_tdata[0 +: IN_RANGE_W],
                       s_axis_tdata[IN_RANGE_W +: IN_RANGE_W], next_res);
        expected_steps.push_back(next_res);
      end
      outstanding_o <= expected_steps.size();
    end
  end

endmodule

`default_nettype wire

// File: verif/testbench.sv
// top of the wall alignment sequencer bench: clock, reset, stimulus, result sink, verdict
// depends on drwas_pkg, dual_range_wall_align_sequencer_core and align_step_checker
`default_nettype none

module testbench;
  import drwas_pkg::*;

  typedef enum int {SET_LOWEST, SET_HIGHEST, SET_RANDOM} setting_e;

  localparam logic [CFG_ADDR_W-1:0] REG_SPARE_IDX = 3'd7;
  localparam int WATCHDOG_CYCLES  = 2000;
  localparam int LONG_HOLD_CYCLES = 40;
  localparam int SETTLE_CYCLES    = 3;
  localparam int MIN_ITEMS        = 520;
  localparam int MIN_SCENARIOS    = 4;
  localparam int RANGE_TOP        = 1023;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [S_TDATA_W-1:0]  s_axis_tdata = '0;
  logic                  s_axis_tuser = 1'b0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b1;
  logic [M_TDATA_W-1:0]  m_axis_tdata;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_ADDR_W-1:0] cfg_addr_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  int outstanding, mismatches;

  // stimulus shaping
  int items_sent = 0;
  bit quiet_tail = 1'b0;
  bit tx_gaps_on = 1'b1;
  int wall_cm, skew_cm, jitter_cm, bad_pct;

  // sink and watchdog state
  int hold_cycles = 0;
  int results_taken = 0;
  int next_long_hold = 150;
  int rx_cycles = 0;
  bit rx_idle_on = 1'b1;
  int stall_cycles = 0;

  dual_range_wall_align_sequencer_core i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_data_i   (cfg_data_i)
  );

  align_step_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_data_i   (cfg_data_i),
    .outstanding_o(outstanding),
    .mismatches_o (mismatches)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // result sink: random short holds, a long hold now and then, none in the tail
  always @(posedge clk_i) begin
    rx_cycles = rx_cycles + 1;
    if (rx_cycles % 64 == 0) rx_idle_on = ($urandom_range(0, 2) != 0);
    if (m_axis_tvalid && m_axis_tready) results_taken = results_taken + 1;
    if (!rst_ni) begin
      m_axis_tready <= 1'b1;
    end else if (hold_cycles > 0) begin
      hold_cycles = hold_cycles - 1;
      m_axis_tready <= 1'b0;
    end else if (!quiet_tail && results_taken >= next_long_hold) begin
      next_long_hold = next_long_hold + 1500;
      hold_cycles = LONG_HOLD_CYCLES - 1;
      m_axis_tready <= 1'b0;
    end else if (!quiet_tail && rx_idle_on && $urandom_range(0, 5) == 0) begin
      hold_cycles = $urandom_range(0, 2);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_CYCLES) begin
        $display("CHECK FAILED");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // one input transfer, then maybe a short gap
  task automatic put_item(input logic kind, input logic [IN_RANGE_W-1:0] lv,
                          input logic [IN_RANGE_W-1:0] rv);
    logic [S_TDATA_W-1:0] word;
    word = '0;
    word[0 +: IN_RANGE_W] = lv;
    word[IN_RANGE_W +: IN_RANGE_W] = rv;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= word;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    items_sent = items_sent + 1;
    if (!quiet_tail && tx_gaps_on && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
  endtask

  // valid stays high across back-to-back writes; the caller lowers it
  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  // stop sending and wait until every result is back
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic load_settings(input setting_e flavor);
    logic [15:0] junk;
    logic [7:0]  tol, conf, lim, slack;
    logic [15:0] tmo, turn;
    logic [8:0]  target;
    junk = 16'($urandom_range(0, 65535));
    case (flavor)
      SET_LOWEST: begin
        tol = 8'd0; conf = 8'd1; lim = 8'd1; tmo = 16'd0; turn = 16'd0;
        target = 9'd0; slack = 8'd0;
      end
      SET_HIGHEST: begin
        tol = 8'd255; conf = 8'd255; lim = 8'd255; tmo = 16'd65535; turn = 16'd65535;
        target = 9'd299; slack = 8'd255;
      end
      default: begin
        tol    = 8'($urandom_range(0, 6));
        conf   = 8'($urandom_range(1, 3));
        lim    = 8'($urandom_range(1, 6));
        case ($urandom_range(0, 3))
          0:       tmo = 16'($urandom_range(0, 700));
          1:       tmo = 16'd3000;
          2:       tmo = 16'($urandom_range(0, 65535));
          default: tmo = 16'($urandom_range(150, 400));
        endcase
        turn   = 16'($urandom_range(0, 60));
        target = 9'($urandom_range(5, 60));
        slack  = 8'($urandom_range(0, 5));
      end
    endcase
    // narrow registers get junk above their width, which must be dropped
    write_reg(REG_EQUAL_TOL,    {junk[7:0], tol});
    write_reg(REG_CONFIRM_NEED, {junk[15:8], conf});
    write_reg(REG_FAULT_LIMIT,  {junk[11:4], lim});
    write_reg(REG_FAULT_TMO,    tmo);
    write_reg(REG_TURN_TIME,    turn);
    write_reg(REG_TARGET_DIST,  {junk[6:0], target});
    write_reg(REG_DIST_SLACK,   {junk[9:2], slack});
    if (flavor == SET_LOWEST) write_reg(REG_SPARE_IDX, junk);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  function automatic int bad_reading();
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return RANGE_TOP;
      default: return $urandom_range(INVALID_FROM, RANGE_TOP);
    endcase
  endfunction

  // wall distance, left-right skew, noise, invalid rate and input gaps of one run
  task automatic shape_scenario();
    wall_cm   = $urandom_range(20, 160);
    jitter_cm = $urandom_range(0, 2);
    case ($urandom_range(0, 4))
      0, 1:    skew_cm = 0;
      2:       skew_cm = $urandom_range(1, 4);
      default: skew_cm = $urandom_range(5, 40);
    endcase
    if ($urandom_range(0, 1) == 1) skew_cm = -skew_cm;
    case ($urandom_range(0, 4))
      0, 1:    bad_pct = 0;
      2, 3:    bad_pct = $urandom_range(3, 12);
      default: bad_pct = 60;
    endcase
    tx_gaps_on = ($urandom_range(0, 3) != 0);
  endtask

  // one tick: the wall closes in slowly, the skew sometimes settles
  task automatic send_tick();
    int lv, rv, j;
    j  = $urandom_range(0, 2 * jitter_cm);
    lv = wall_cm + j - jitter_cm;
    j  = $urandom_range(0, 2 * jitter_cm);
    rv = wall_cm + skew_cm + j - jitter_cm;
    if (lv < 1) lv = 1;
    if (lv > RANGE_TOP) lv = RANGE_TOP;
    if (rv < 1) rv = 1;
    if (rv > RANGE_TOP) rv = RANGE_TOP;
    if ($urandom_range(0, 99) < bad_pct) lv = bad_reading();
    if ($urandom_range(0, 99) < bad_pct) rv = bad_reading();
    if ($urandom_range(0, 3) == 0 && wall_cm > 1) wall_cm = wall_cm - 1;
    if ($urandom_range(0, 149) == 0) skew_cm = 0;
    put_item(1'b0, lv[IN_RANGE_W-1:0], rv[IN_RANGE_W-1:0]);
  endtask

  // a start, then ticks with a rare restart in whatever phase is current
  task automatic run_scenario(input int ticks);
    put_item(1'b1, IN_RANGE_W'($urandom_range(0, RANGE_TOP)),
             IN_RANGE_W'($urandom_range(0, RANGE_TOP)));
    for (int i = 0; i < ticks; i++) begin
      if ($urandom_range(0, 499) == 0)
        put_item(1'b1, IN_RANGE_W'($urandom_range(0, RANGE_TOP)),
                 IN_RANGE_W'($urandom_range(0, RANGE_TOP)));
      else
        send_tick();
    end
  endtask

  initial begin
    int scen;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: ticks while idle, field extremes, alternating bits, restarts
    put_item(1'b0, 10'd0, 10'd0);
    put_item(1'b0, 10'd1023, 10'd1023);
    put_item(1'b0, 10'h155, 10'h2AA);
    put_item(1'b0, 10'h2AA, 10'h155);
    put_item(1'b1, 10'd1023, 10'd0);
    put_item(1'b1, 10'd0, 10'd1023);
    put_item(1'b0, 10'd299, 10'd300);
    put_item(1'b0, 10'd1, 10'd1);
    put_item(1'b1, 10'h155, 10'h2AA);
    put_item(1'b0, 10'd300, 10'd299);
    put_item(1'b0, 10'h2AA, 10'h155);
    put_item(1'b1, 10'd1023, 10'd1023);
    put_item(1'b0, 10'd0, 10'd1023);

    // random runs, reconfigured between runs only once the block is idle
    scen = 0;
    while (items_sent < MIN_ITEMS || scen < MIN_SCENARIOS) begin
      if (scen == 1) begin
        drain_results();
        load_settings(SET_LOWEST);
      end else if (scen == 2) begin
        drain_results();
        load_settings(SET_HIGHEST);
      end else if (scen > 2 && $urandom_range(0, 1) == 1) begin
        drain_results();
        load_settings(SET_RANDOM);
      end
      shape_scenario();
      if (scen == 0) run_scenario(180);
      else if (scen == 1) run_scenario(200);
      else if (scen == 2) run_scenario(60);
      else run_scenario($urandom_range(80, 160));
      scen = scen + 1;
    end

    // tail without any idling
    quiet_tail = 1'b1;
    shape_scenario();
    run_scenario(40);

    drain_results();
    if (mismatches == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

// File: filelist.f
+incdir+hdl
hdl/drwas_pkg.sv
hdl/dual_range_wall_align_sequencer_core.sv
hdl/drwas_checker.sv
verif/align_step_checker.sv
verif/testbench.sv
